>>> rtl/core/svt_pkg.sv
// Shared types and constants for the sorted value table.
// No dependencies; compiled before the channel interfaces and the top level.
package svt_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int OPC_W  = 3;
   localparam int POS_W  = 10;
   localparam int VAL_W  = 16;
   localparam int CNT_W  = 11;

   typedef enum logic [OPC_W-1:0] {
      OP_INIT    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_READ    = 3'd2,
      OP_FIND    = 3'd3,
      OP_NEXT    = 3'd4,
      OP_DEL_VAL = 3'd5,
      OP_DEL_IDX = 3'd6,
      OP_COUNT   = 3'd7
   } opcode_type;

endpackage

>>> rtl/core/svt_req_if.sv
// Request channel of the sorted value table: valid/ready plus one request word.
// Depends on svt_pkg for field widths.
interface svt_req_if;
   import svt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OPC_W-1:0]   opcode;
   logic [POS_W-1:0]   position;
   logic [VAL_W-1:0]   value;
   logic [CNT_W-1:0]   new_count;

   modport source (output valid, opcode, position, value, new_count, input ready);
   modport sink   (input valid, opcode, position, value, new_count, output ready);
endinterface

>>> rtl/core/svt_rsp_if.sv
// Response channel of the sorted value table: valid/ready plus one result word.
// Depends on svt_pkg for field widths.
interface svt_rsp_if;
   import svt_pkg::*;

   logic               valid;
   logic               ready;
   logic               ok;
   logic [VAL_W-1:0]   data;
   logic [POS_W-1:0]   found_index;
   logic [CNT_W-1:0]   entries;

   modport source (output valid, ok, data, found_index, entries, input ready);
   modport sink   (input valid, ok, data, found_index, entries, output ready);
endinterface

>>> rtl/core/sorted_value_table_top.sv
// Sorted value table: DEPTH 16-bit values kept in ascending logical order in one
// single-port-read, single-port-write RAM (registered read data), stored reversed so
// logical index i sits at slot count-1-i. One request word is worked at a time and
// answered by exactly one response word, held in an output register until taken.
// Find, next and delete value binary-search with one RAM probe per search step; next
// adds an extra RAM read; delete value / delete index move the words above the freed
// slot down, one RAM word moved per cycle; init clears one slot per cycle. After reset
// the RAM is cleared the same way, and req ready stays low until the clear is done.
// Depends on svt_pkg, svt_req_if and svt_rsp_if.
module sorted_value_table_top #(
   parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   svt_req_if.sink    req_ch,
   svt_rsp_if.source  rsp_ch
);
   import svt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // slot address
   localparam int CW = $clog2(DEPTH + 1);                 // entry count
   localparam int SW = AW + 1;                            // probe sums

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FIN,
      ST_LOAD_RD,
      ST_LOAD_WAIT,
      ST_SRCH_ISSUE,
      ST_SRCH_CMP,
      ST_SHIFT_START,
      ST_SHIFT
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type         state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [VAL_W-1:0]  key_ff, key_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     l_ff, l_in;       // search low bound
   logic [AW-1:0]     h_ff, h_in;       // search high bound
   logic [AW-1:0]     m_ff, m_in;       // current probe slot
   logic [AW-1:0]     k_ff, k_in;       // sweep / shift / load slot
   logic              init_rsp_ff, init_rsp_in;  // clear pass belongs to an init word
   logic              res_ok_ff, res_ok_in;
   logic [VAL_W-1:0]  res_data_ff, res_data_in;
   logic [POS_W-1:0]  res_fidx_ff, res_fidx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [VAL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]  rsp_fidx_ff, rsp_fidx_in;
   logic [CNT_W-1:0]  rsp_entries_ff, rsp_entries_in;

   // ---------------------------------------------------------------- value RAM
   logic [VAL_W-1:0]  value_store [DEPTH];
   logic [VAL_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [VAL_W-1:0]  mem_wd;
   logic [AW-1:0]     mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_store[mem_wa] <= mem_wd;
      end
      rd_data_ff <= value_store[mem_ra];
   end

   // ---------------------------------------------------------------- datapath
   logic              req_fire;
   logic              in_range;
   logic [AW-1:0]     phys;
   logic [AW-1:0]     last_slot;
   logic [SW-1:0]     sum_lt, sum_gt;
   logic [AW-1:0]     m_lt, m_gt;
   logic              probe_eq, probe_lt;
   logic [POS_W-1:0]  probe_fidx;

   assign req_fire  = req_ch.valid && (state_ff == ST_IDLE);
   assign in_range  = 32'(req_ch.position) < 32'(cnt_ff);
   assign phys      = AW'(cnt_ff - CW'(1) - CW'(req_ch.position));
   assign last_slot = AW'(cnt_ff - CW'(1));

   // Both candidate next probes are formed alongside the compare.
   assign sum_lt     = SW'(l_ff) + SW'(m_ff) - SW'(1);
   assign sum_gt     = SW'(m_ff) + SW'(h_ff) + SW'(1);
   assign m_lt       = AW'(sum_lt >> 1);
   assign m_gt       = AW'(sum_gt >> 1);
   assign probe_eq   = (rd_data_ff == key_ff);
   assign probe_lt   = (rd_data_ff < key_ff);   // store descends: go to lower slots
   assign probe_fidx = POS_W'(cnt_ff - CW'(1) - CW'(m_ff));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      cnt_in         = cnt_ff;
      l_in           = l_ff;
      h_in           = h_ff;
      m_in           = m_ff;
      k_in           = k_ff;
      init_rsp_in    = init_rsp_ff;
      res_ok_in      = res_ok_ff;
      res_data_in    = res_data_ff;
      res_fidx_in    = res_fidx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_fidx_in    = rsp_fidx_ff;
      rsp_entries_in = rsp_entries_ff;
      mem_we         = 1'b0;
      mem_wa         = k_ff;
      mem_wd         = '0;
      mem_ra         = m_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = opcode_type'(req_ch.opcode);
               key_in      = req_ch.value;
               res_ok_in   = 1'b0;
               res_data_in = '0;
               res_fidx_in = '0;
               state_in    = ST_FIN;
               case (opcode_type'(req_ch.opcode))
                  OP_INIT: begin
                     if (32'(req_ch.new_count) > DEPTH) begin
                        cnt_in = CW'(DEPTH);     // saturate, ok stays low
                     end else begin
                        cnt_in    = CW'(req_ch.new_count);
                        res_ok_in = 1'b1;
                     end
                     k_in        = '0;
                     init_rsp_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  OP_WRITE: begin
                     if (in_range) begin
                        mem_we    = 1'b1;
                        mem_wa    = phys;
                        mem_wd    = req_ch.value;
                        res_ok_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (in_range) begin
                        k_in     = phys;
                        state_in = ST_LOAD_RD;
                     end
                  end
                  OP_FIND, OP_NEXT, OP_DEL_VAL: begin
                     if (cnt_ff != '0) begin
                        l_in     = '0;
                        h_in     = last_slot;
                        m_in     = AW'((cnt_ff - CW'(1)) >> 1);
                        state_in = ST_SRCH_ISSUE;
                     end
                  end
                  OP_DEL_IDX: begin
                     if (in_range) begin
                        k_in      = phys;
                        res_ok_in = 1'b1;
                        state_in  = ST_SHIFT_START;
                     end
                  end
                  OP_COUNT: begin
                     res_ok_in = 1'b1;
                  end
                  default: begin
                     res_ok_in = 1'b1;
                  end
               endcase
            end
         end

         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = k_ff;
            if (k_ff == AW'(DEPTH - 1)) begin
               state_in    = init_rsp_ff ? ST_FIN : ST_IDLE;
               init_rsp_in = 1'b0;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end

         ST_LOAD_RD: begin
            mem_ra   = k_ff;
            state_in = ST_LOAD_WAIT;
         end

         ST_LOAD_WAIT: begin
            res_ok_in   = 1'b1;
            res_data_in = rd_data_ff;
            state_in    = ST_FIN;
         end

         ST_SRCH_ISSUE: begin
            mem_ra   = m_ff;
            state_in = ST_SRCH_CMP;
         end

         ST_SRCH_CMP: begin
            mem_ra   = probe_lt ? m_lt : m_gt;
            state_in = ST_FIN;
            if (probe_eq) begin
               case (op_ff)
                  OP_FIND: begin
                     res_ok_in   = 1'b1;
                     res_fidx_in = probe_fidx;
                  end
                  OP_NEXT: begin
                     if (m_ff != '0) begin
                        k_in     = m_ff - AW'(1);
                        state_in = ST_LOAD_RD;
                     end
                  end
                  OP_DEL_VAL: begin
                     res_ok_in   = 1'b1;
                     res_fidx_in = probe_fidx;
                     k_in        = m_ff;
                     state_in    = ST_SHIFT_START;
                  end
                  default: begin
                  end
               endcase
            end else if (probe_lt) begin
               if (l_ff < m_ff) begin
                  h_in     = m_ff - AW'(1);
                  m_in     = m_lt;
                  state_in = ST_SRCH_CMP;
               end else if (op_ff == OP_NEXT && m_ff != '0) begin
                  // miss with high bound at m-1 (none when m is slot zero)
                  k_in     = m_ff - AW'(1);
                  state_in = ST_LOAD_RD;
               end
            end else begin
               if (m_ff < h_ff) begin
                  l_in     = m_ff + AW'(1);
                  m_in     = m_gt;
                  state_in = ST_SRCH_CMP;
               end else if (op_ff == OP_NEXT) begin
                  k_in     = h_ff;
                  state_in = ST_LOAD_RD;
               end
            end
         end

         ST_SHIFT_START: begin
            mem_ra   = k_ff + AW'(1);
            state_in = ST_SHIFT;
         end

         ST_SHIFT: begin
            // rd_data_ff holds slot k+1; move it down and fetch k+2
            mem_we = 1'b1;
            mem_wa = k_ff;
            if (k_ff < last_slot) begin
               mem_wd = rd_data_ff;
               mem_ra = k_ff + AW'(2);
               k_in   = k_ff + AW'(1);
            end else begin
               cnt_in   = cnt_ff - CW'(1);   // top slot cleared
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_ok_in      = res_ok_ff;
               rsp_data_in    = res_data_ff;
               rsp_fidx_in    = res_fidx_ff;
               rsp_entries_in = CNT_W'(cnt_ff);
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         k_ff         <= '0;
         init_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         init_rsp_ff  <= init_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      l_ff           <= l_in;
      h_ff           <= h_in;
      m_ff           <= m_in;
      res_ok_ff      <= res_ok_in;
      res_data_ff    <= res_data_in;
      res_fidx_ff    <= res_fidx_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_fidx_ff    <= rsp_fidx_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.data        = rsp_data_ff;
   assign rsp_ch.found_index = rsp_fidx_ff;
   assign rsp_ch.entries     = rsp_entries_ff;

endmodule

>>> rtl/core/svt_checker.sv
// Port-level assertions for the sorted value table, bound to the top level.
// Depends on svt_pkg for field widths and on sorted_value_table_top for the bind.
module svt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_ok,
   input logic [svt_pkg::VAL_W-1:0] rsp_data,
   input logic [svt_pkg::POS_W-1:0] rsp_found_index,
   input logic [svt_pkg::CNT_W-1:0] rsp_entries
);
   import svt_pkg::*;

   logic       req_fire, rsp_fire;
   logic [1:0] pend_ff, pend_in;   // words accepted but not yet answered

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + 2'(req_fire) - 2'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_data)
         && $stable(rsp_found_index) && $stable(rsp_entries))
      else $error("response word changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("table not quiet during clear after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while one is still at work");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pend_ff != 2'd0)
      else $error("response word without a request");

endmodule

bind sorted_value_table_top svt_checker u_svt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_ok          (rsp_ch.ok),
   .rsp_data        (rsp_ch.data),
   .rsp_found_index (rsp_ch.found_index),
   .rsp_entries     (rsp_ch.entries)
);

>>> test/sorted_value_table_top_tb.sv
// Self-checking testbench for sorted_value_table_top: request and response streams
// under random idling, with a built-in table predictor. Depends on svt_pkg,
// svt_req_if, svt_rsp_if and the RTL top level.
module sorted_value_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svt_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int ITEM_TARGET  = 750;
   // The generator keeps a planning copy of the table to pick useful keys; the
   // driver keeps the live copy that produces the expected results.
   localparam int PLAN         = 0;
   localparam int LIVE         = 1;
   localparam int HOLD_AT      = 150;   // result number that starts the long stall
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      opcode_type       op;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] new_count;
      logic             drain;          // wait for every result before offering
   } request_word_type;

   typedef struct packed {
      logic             ok;
      logic [VAL_W-1:0] data;
      logic [POS_W-1:0] found_index;
      logic [CNT_W-1:0] entries;
   } result_word_type;

   logic clock;
   logic reset;

   svt_req_if req_ch ();
   svt_rsp_if rsp_ch ();

   sorted_value_table_top #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: two copies of the store (plan, live) and their counts.
   // Logical index i lives at physical slot fill-1-i, values descend physically.
   // ---------------------------------------------------------------------------
   logic [VAL_W-1:0] slots [2][DEPTH];
   int               fill  [2];

   request_word_type req_backlog [$];   // words still to be offered
   result_word_type  due_results [$];   // expected responses, oldest first
   request_word_type cur_req = '0;
   bit               sender_busy;       // mirrors req valid

   int     n_items;
   int     n_accepted;
   int     n_results;
   int     n_ok;
   int     fail_count;
   int     hold_left;
   int     op_seen [8];
   longint est_cycles;
   longint cycle_limit = 64'd100_000_000;
   longint cycle_count;

   // Binary search over the descending physical store. probe gets the last slot
   // looked at, upper the final high bound (may end at -1).
   function automatic bit search_slots(input int side, input logic [VAL_W-1:0] key,
                                       output int probe, output int upper);
      int lo, mid, hi;
      lo  = 0;
      mid = 0;
      hi  = fill[side] - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (slots[side][mid] == key)
            break;
         if (slots[side][mid] < key)
            hi = mid - 1;
         else
            lo = mid + 1;
      end
      probe = mid;
      upper = hi;
      return slots[side][mid] == key;
   endfunction

   // Remove one logical entry: lower logical entries (higher slots) slide down one
   // slot, the freed top slot is cleared and the count drops.
   function automatic void drop_entry(input int side, input int logical);
      int s;
      for (s = fill[side] - 1 - logical; s < fill[side] - 1; s++)
         slots[side][s] = slots[side][s + 1];
      slots[side][fill[side] - 1] = '0;
      fill[side]--;
   endfunction

   // Applies one request word to one copy of the table and returns its response.
   function automatic result_word_type apply_request(input int side,
                                                     input request_word_type rq);
      result_word_type rs;
      int              probe, upper, i;
      rs = '0;
      case (rq.op)
         OP_INIT: begin
            for (i = 0; i < DEPTH; i++)
               slots[side][i] = '0;
            if (rq.new_count > DEPTH) begin
               fill[side] = DEPTH;        // saturates, reported as failure
            end else begin
               fill[side] = int'(rq.new_count);
               rs.ok      = 1'b1;
            end
         end
         OP_WRITE: begin
            if (rq.position < fill[side]) begin
               slots[side][fill[side] - 1 - rq.position] = rq.value;
               rs.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (rq.position < fill[side]) begin
               rs.data = slots[side][fill[side] - 1 - rq.position];
               rs.ok   = 1'b1;
            end
         end
         OP_FIND: begin
            if (fill[side] > 0 && search_slots(side, rq.value, probe, upper)) begin
               rs.found_index = POS_W'(fill[side] - 1 - probe);
               rs.ok          = 1'b1;
            end
         end
         OP_NEXT: begin
            if (fill[side] > 0) begin
               if (search_slots(side, rq.value, probe, upper)) begin
                  // hit: the next larger value sits one slot down, if any
                  if (probe != 0) begin
                     rs.data = slots[side][probe - 1];
                     rs.ok   = 1'b1;
                  end
               end else if (upper >= 0) begin
                  rs.data = slots[side][upper];
                  rs.ok   = 1'b1;
               end
            end
         end
         OP_DEL_VAL: begin
            if (fill[side] > 0 && search_slots(side, rq.value, probe, upper)) begin
               rs.found_index = POS_W'(fill[side] - 1 - probe);
               drop_entry(side, fill[side] - 1 - probe);
               rs.ok = 1'b1;
            end
         end
         OP_DEL_IDX: begin
            if (rq.position < fill[side]) begin
               drop_entry(side, int'(rq.position));
               rs.ok = 1'b1;
            end
         end
         default: rs.ok = 1'b1;
      endcase
      rs.entries = CNT_W'(fill[side]);
      return rs;
   endfunction

   function automatic logic [VAL_W-1:0] plan_value(input int logical);
      return slots[PLAN][fill[PLAN] - 1 - logical];
   endfunction

   // Queues one word for the driver, steps the planning copy and adds a rough
   // upper bound of its block cycles to the run estimate.
   function automatic void add_item(input opcode_type op, input int pos, input int val,
                                    input int ncnt, input bit drain = 1'b0);
      request_word_type rq;
      rq.op        = op;
      rq.position  = POS_W'(pos);
      rq.value     = VAL_W'(val);
      rq.new_count = CNT_W'(ncnt);
      rq.drain     = drain;
      case (op)
         OP_INIT:                est_cycles += DEPTH + 4;
         OP_DEL_VAL, OP_DEL_IDX: est_cycles += fill[PLAN] + 24;
         OP_FIND, OP_NEXT:       est_cycles += 24;
         default:                est_cycles += 6;
      endcase
      est_cycles += 150;   // allowance for sender gaps and receiver stalls
      void'(apply_request(PLAN, rq));
      req_backlog.push_back(rq);
   endfunction

   // Key for find / next / delete value: mostly a stored value, else anything.
   function automatic int pick_key();
      if (fill[PLAN] > 0 && $urandom_range(99) < 60)
         return plan_value($urandom_range(fill[PLAN] - 1, 0));
      return $urandom_range(16'hFFFF, 0);
   endfunction

   // In-range position most of the time, else anything the field holds.
   function automatic int pick_pos();
      if (fill[PLAN] > 0 && $urandom_range(99) < 85)
         return $urandom_range(fill[PLAN] - 1, 0);
      return $urandom_range(10'h3FF, 0);
   endfunction

   // ---------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run guard: the limit comes from the generator's cycle estimate.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("%0t: timeout after %0d cycles, %0d results still due",
                  $realtime, cycle_count, due_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus build, reset and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int n, k, j, r, pos, lo_v, hi_v, step, n_seq;
      bit noise_seq;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = '0;
      req_ch.position    = '0;
      req_ch.value       = '0;
      req_ch.new_count   = '0;
      rsp_ch.ready       = 1'b0;

      fill[PLAN] = 0;
      fill[LIVE] = 0;
      for (j = 0; j < DEPTH; j++) begin
         slots[PLAN][j] = '0;
         slots[LIVE][j] = '0;
      end

      // Directed: empty table, full-size table, saturating and zero init, then
      // a small ordered table for hits, misses and next-value corner cases.
      add_item(OP_COUNT,   0, 0, 0);
      add_item(OP_FIND,    0, 0, 0);        // empty table
      add_item(OP_NEXT,    0, 0, 0);
      add_item(OP_DEL_VAL, 0, 0, 0);
      add_item(OP_READ,    0, 0, 0);        // index beyond count
      add_item(OP_WRITE,   0, 16'h1234, 0);
      add_item(OP_DEL_IDX, 0, 0, 0);
      add_item(OP_INIT,    0, 0, DEPTH);    // full capacity is allowed
      add_item(OP_WRITE,   DEPTH - 1, 16'hFFFF, 0);
      add_item(OP_READ,    DEPTH - 1, 0, 0);
      add_item(OP_DEL_IDX, DEPTH - 1, 0, 0);  // longest shift
      add_item(OP_INIT,    0, 0, 11'h7FF);  // beyond capacity: saturates
      add_item(OP_INIT,    0, 0, DEPTH + 1);
      add_item(OP_INIT,    0, 0, 0);        // zero entries
      add_item(OP_INIT,    0, 0, 4);
      add_item(OP_WRITE,   0, 0, 0);
      add_item(OP_WRITE,   1, 100, 0);
      add_item(OP_WRITE,   2, 200, 0);
      add_item(OP_WRITE,   3, 300, 0);
      add_item(OP_FIND,    0, 100, 0);
      add_item(OP_FIND,    0, 50, 0);       // miss
      add_item(OP_NEXT,    0, 50, 0);
      add_item(OP_NEXT,    0, 300, 0);      // largest stored value
      add_item(OP_NEXT,    0, 16'hFFFF, 0); // nothing larger
      add_item(OP_DEL_VAL, 0, 200, 0);
      add_item(OP_DEL_IDX, 0, 0, 0);
      add_item(OP_COUNT,   0, 0, 0);

      // Random: mostly ordered tables with random content and traffic, some
      // sequences of raw noise.
      n_seq = 0;
      while (req_backlog.size() < ITEM_TARGET) begin
         n_seq++;
         noise_seq = ($urandom_range(99) < 10);
         if (noise_seq) begin
            for (k = 0; k < 6; k++)
               add_item(opcode_type'($urandom_range(7, 0)), $urandom_range(10'h3FF, 0),
                        $urandom_range(16'hFFFF, 0), $urandom_range(11'h7FF, 0));
         end else begin
            r = $urandom_range(99);
            if (r < 60)      n = $urandom_range(16, 1);
            else if (r < 85) n = $urandom_range(64, 17);
            else if (r < 93) n = $urandom_range(300, 65);
            else if (r < 97) n = 0;
            else             n = DEPTH;
            add_item(OP_INIT, 0, 0, n, (n_seq % 4) == 0);
            if (n <= 64) begin
               // strictly ascending, one disjoint value band per entry
               step = (n > 0) ? 65536 / n : 1;
               for (j = 0; j < n; j++)
                  add_item(OP_WRITE, j, 0, 0);
               for (j = 0; j < n; j++)
                  req_backlog[req_backlog.size() - n + j].value = '0;
               // rewrite in place: the plan copy must see the real values too
               for (j = 0; j < n; j++)
                  add_item(OP_WRITE, j, j * step + $urandom_range(step - 1, 0), 0);
            end else begin
               for (j = 0; j < 8; j++)
                  add_item(OP_WRITE, j * n / 8, j * 8000 + $urandom_range(7999, 0), 0);
            end
            k = $urandom_range(20, 6);
            for (j = 0; j < k; j++) begin
               r = $urandom_range(99);
               if (r < 15)      add_item(OP_READ, pick_pos(), 0, 0);
               else if (r < 30) add_item(OP_FIND, 0, pick_key(), 0);
               else if (r < 45) add_item(OP_NEXT, 0, pick_key(), 0);
               else if (r < 57) add_item(OP_DEL_VAL, 0, pick_key(), 0);
               else if (r < 67) add_item(OP_DEL_IDX, pick_pos(), 0, 0);
               else if (r < 72) add_item(OP_COUNT, 0, 0, 0);
               else if (r < 87) begin
                  // write that keeps the order when the neighbors leave room
                  pos = pick_pos();
                  lo_v = 0;
                  hi_v = 16'hFFFF;
                  if (pos < fill[PLAN]) begin
                     if (pos > 0)
                        lo_v = int'(plan_value(pos - 1)) + 1;
                     if (pos < fill[PLAN] - 1)
                        hi_v = int'(plan_value(pos + 1)) - 1;
                  end
                  if (lo_v <= hi_v)
                     add_item(OP_WRITE, pos, $urandom_range(hi_v, lo_v), 0);
                  else
                     add_item(OP_WRITE, pos, $urandom_range(16'hFFFF, 0), 0);
               end else begin
                  add_item(opcode_type'($urandom_range(7, 0)), $urandom_range(10'h3FF, 0),
                           $urandom_range(16'hFFFF, 0), $urandom_range(11'h7FF, 0));
               end
            end
         end
      end

      n_items = req_backlog.size();
      // clearing pass after reset, the long stall and the tail, then 4x margin
      cycle_limit = 4 * (est_cycles + 4 * DEPTH + HOLD_CYCLES + 200) + 10_000;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || sender_busy || due_results.size() != 0)
         @(posedge clock);
      // anything arriving now would be an extra response
      repeat (2 * DEPTH + 64) @(posedge clock);

      $display("Checked %0d responses for %0d requests, %0d with ok set, %0d mismatches.",
               n_results, n_accepted, n_ok, fail_count);
      $display("Ops: init %0d wr %0d rd %0d find %0d next %0d delv %0d deli %0d cnt %0d",
               op_seen[OP_INIT], op_seen[OP_WRITE], op_seen[OP_READ], op_seen[OP_FIND],
               op_seen[OP_NEXT], op_seen[OP_DEL_VAL], op_seen[OP_DEL_IDX], op_seen[OP_COUNT]);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Driver: offers backlog words. Idle odds by thirds of the run: 17%, 84%,
   // none. A word flagged drain waits until every response has come back.
   // The expected response is computed when the word is accepted.
   // ---------------------------------------------------------------------------
   int sender_idle_pct;
   bit launch;

   always @(posedge clock) begin
      if (reset) begin
         sender_busy   = 1'b0;
         req_ch.valid <= 1'b0;
      end else begin
         if (sender_busy && req_ch.ready) begin
            due_results.push_back(apply_request(LIVE, cur_req));
            op_seen[cur_req.op]++;
            n_accepted++;
            sender_busy = 1'b0;
         end
         if (!sender_busy && req_backlog.size() != 0) begin
            case (n_accepted * 3 / n_items)
               0:       sender_idle_pct = 17;
               1:       sender_idle_pct = 84;
               default: sender_idle_pct = 0;
            endcase
            launch = !(req_backlog[0].drain && due_results.size() != 0) &&
                     ($urandom_range(99) >= sender_idle_pct);
            if (launch) begin
               cur_req     = req_backlog.pop_front();
               sender_busy = 1'b1;
            end
         end
         // valid stays high until taken; one assignment per edge
         req_ch.valid     <= sender_busy;
         req_ch.opcode    <= cur_req.op;
         req_ch.position  <= cur_req.position;
         req_ch.value     <= cur_req.value;
         req_ch.new_count <= cur_req.new_count;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: takes responses and checks them against the oldest expectation.
   // Ready idles 84%, then 17%, then never; once, after HOLD_AT responses, it
   // holds ready low until hold_left runs out, so the block backs up and
   // stalls its input. Words print as ok, data, found index, entries.
   // ---------------------------------------------------------------------------
   result_word_type got_rsp, want_rsp;
   int              rcvr_idle_pct;
   bit              take;

   always @(posedge clock) begin
      if (reset) begin
         hold_left     = 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_rsp.ok          = rsp_ch.ok;
            got_rsp.data        = rsp_ch.data;
            got_rsp.found_index = rsp_ch.found_index;
            got_rsp.entries     = rsp_ch.entries;
            n_results++;
            if (got_rsp.ok === 1'b1)
               n_ok++;
            if (due_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word: expected none, actual %b %h %0d %0d",
                        $realtime, got_rsp.ok, got_rsp.data, got_rsp.found_index,
                        got_rsp.entries);
            end else begin
               want_rsp = due_results.pop_front();
               if (got_rsp.ok !== want_rsp.ok || got_rsp.data !== want_rsp.data ||
                   got_rsp.found_index !== want_rsp.found_index ||
                   got_rsp.entries !== want_rsp.entries) begin
                  fail_count++;
                  $display("%0t: word %0d expected %b %h %0d %0d, actual %b %h %0d %0d",
                           $realtime, n_results, want_rsp.ok, want_rsp.data,
                           want_rsp.found_index, want_rsp.entries, got_rsp.ok,
                           got_rsp.data, got_rsp.found_index, got_rsp.entries);
               end
            end
            if (n_results == HOLD_AT)
               hold_left = HOLD_CYCLES;
         end
         case (n_results * 3 / n_items)
            0:       rcvr_idle_pct = 84;
            1:       rcvr_idle_pct = 17;
            default: rcvr_idle_pct = 0;
         endcase
         if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            take = ($urandom_range(99) >= rcvr_idle_pct);
         end
         rsp_ch.ready <= take;
      end
   end

endmodule

>>> files.f
rtl/core/svt_pkg.sv
rtl/core/svt_req_if.sv
rtl/core/svt_rsp_if.sv
rtl/core/sorted_value_table_top.sv
rtl/core/svt_checker.sv
test/sorted_value_table_top_tb.sv
